@@ hdl/lcdc_pkg.sv @@
// Shared types and constants for the page-addressed LCD controller.
// Holds the request/result payload structs, command codes and panel geometry.
// No dependencies.
package lcdc_pkg;

  // Panel geometry
  localparam int WIDTH_PX         = 96;
  localparam int HEIGHT_PX        = 64;
  localparam int COLUMNS_PER_PAGE = 128;
  localparam int NUM_PAGES        = 16;

  // Display memory: 4096 bytes, split into an even and an odd bank
  localparam int MEM_AW  = 12;
  localparam int BANK_AW = MEM_AW - 1;

  // Request opcodes (code 3 is a no-op)
  localparam logic [1:0] OP_CMD   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Command byte codes
  localparam logic [7:0] CMD_COL_LO_MIN = 8'h00;
  localparam logic [7:0] CMD_COL_LO_MAX = 8'h0F;
  localparam logic [7:0] CMD_COL_HI_MIN = 8'h10;
  localparam logic [7:0] CMD_COL_HI_MAX = 8'h17;
  localparam logic [7:0] CMD_OFFSET_MIN = 8'h40;
  localparam logic [7:0] CMD_OFFSET_MAX = 8'h43;
  localparam logic [7:0] CMD_PAGE_MIN   = 8'hB0;
  localparam logic [7:0] CMD_PAGE_MAX   = 8'hBF;
  localparam logic [7:0] CMD_CONTRAST   = 8'h81;
  localparam logic [7:0] CMD_SLEEP_ON   = 8'hA9;
  localparam logic [7:0] CMD_SLEEP_OFF  = 8'hE1;

  typedef enum logic [1:0] {
    MODE_WAIT     = 2'd0,
    MODE_CONTRAST = 2'd1,
    MODE_OFFSET   = 2'd2
  } lcdc_mode_t;

  typedef struct packed {
    logic [7:0] contrast;
    logic       sleep;
    logic [6:0] column;
    logic [3:0] page;
    logic [4:0] offset;
  } lcdc_regs_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  byte_value;
    logic [11:0] mem_address;
    logic [6:0]  pixel_x;
    logic [5:0]  pixel_y;
  } lcdc_in_t;

  typedef struct packed {
    logic [1:0] palette_index;
    logic [7:0] contrast_level;
    logic       power_save;
    logic [6:0] column_address;
    logic [3:0] page_address;
    logic [4:0] scroll_pages;
  } lcdc_out_t;

endpackage

@@ hdl/lcdc_cmd_dec.sv @@
// Command byte decoder and controller register file.
// Tracks two-byte sequences with a small state machine; uses lcdc_pkg.
module lcdc_cmd_dec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_we,
  input  logic [7:0]        cmd_byte,
  output lcdc_pkg::lcdc_regs_t regs_o,
  output lcdc_pkg::lcdc_regs_t regs_nxt_o
);

  lcdc_pkg::lcdc_mode_t mode_r, mode_nxt;
  lcdc_pkg::lcdc_regs_t regs_r, regs_nxt;

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    if (cmd_we) begin
      unique case (mode_r)
        lcdc_pkg::MODE_CONTRAST: mode_nxt = lcdc_pkg::MODE_WAIT;
        lcdc_pkg::MODE_OFFSET:   mode_nxt = lcdc_pkg::MODE_WAIT;
        default: begin
          unique case (cmd_byte) inside
            [lcdc_pkg::CMD_OFFSET_MIN:lcdc_pkg::CMD_OFFSET_MAX]:
              mode_nxt = lcdc_pkg::MODE_OFFSET;
            lcdc_pkg::CMD_CONTRAST: mode_nxt = lcdc_pkg::MODE_CONTRAST;
            default:                mode_nxt = lcdc_pkg::MODE_WAIT;
          endcase
        end
      endcase
    end
  end

  // Register updates
  always_comb begin
    regs_nxt = regs_r;
    if (cmd_we) begin
      unique case (mode_r)
        lcdc_pkg::MODE_CONTRAST: regs_nxt.contrast = cmd_byte;
        lcdc_pkg::MODE_OFFSET:   regs_nxt.offset   = cmd_byte[7:3];
        default: begin
          unique case (cmd_byte) inside
            [lcdc_pkg::CMD_COL_LO_MIN:lcdc_pkg::CMD_COL_LO_MAX]:
              regs_nxt.column[3:0] = cmd_byte[3:0];
            [lcdc_pkg::CMD_COL_HI_MIN:lcdc_pkg::CMD_COL_HI_MAX]:
              regs_nxt.column[6:4] = cmd_byte[2:0];
            [lcdc_pkg::CMD_PAGE_MIN:lcdc_pkg::CMD_PAGE_MAX]:
              regs_nxt.page = cmd_byte[3:0];
            lcdc_pkg::CMD_SLEEP_ON:  regs_nxt.sleep = 1'b1;
            lcdc_pkg::CMD_SLEEP_OFF: regs_nxt.sleep = 1'b0;
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lcdc_pkg::MODE_WAIT;
      regs_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      regs_r <= regs_nxt;
    end
  end

  assign regs_o     = regs_r;
  assign regs_nxt_o = regs_nxt;

endmodule

@@ hdl/lcdc_disp_mem.sv @@
// Display memory: even and odd byte banks with registered reads.
// Runs a zero-fill sweep after reset; uses lcdc_pkg.
module lcdc_disp_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [lcdc_pkg::MEM_AW-1:0]  wr_addr,
  input  logic [7:0]                   wr_data,
  input  logic                         rd_en,
  input  logic [lcdc_pkg::BANK_AW-1:0] rd_col,
  output logic [7:0]                   rd_even,
  output logic [7:0]                   rd_odd,
  output logic                         clr_busy
);

  localparam int BANK_DEPTH = 2 ** lcdc_pkg::BANK_AW;

  logic [7:0] bank_even [BANK_DEPTH];
  logic [7:0] bank_odd  [BANK_DEPTH];
  logic [7:0] rd_even_r, rd_odd_r;

  logic                         clr_busy_r, clr_busy_nxt;
  logic [lcdc_pkg::BANK_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // Write port: the sweep owns both banks until done
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      bank_even[clr_cnt_r] <= '0;
      bank_odd[clr_cnt_r]  <= '0;
    end else if (wr_en) begin
      if (wr_addr[0]) begin
        bank_odd[wr_addr[lcdc_pkg::MEM_AW-1:1]] <= wr_data;
      end else begin
        bank_even[wr_addr[lcdc_pkg::MEM_AW-1:1]] <= wr_data;
      end
    end
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_even_r <= bank_even[rd_col];
      rd_odd_r  <= bank_odd[rd_col];
    end
  end

  assign rd_even  = rd_even_r;
  assign rd_odd   = rd_odd_r;
  assign clr_busy = clr_busy_r;

endmodule

@@ hdl/lcd_command_decoder_and_scanout.sv @@
// Page-addressed 2-bit-per-pixel LCD controller: command decode, display
// memory writes and pixel scanout reads. Uses lcdc_pkg, lcdc_cmd_dec and
// lcdc_disp_mem.
//
// Requests arrive on in_valid/in_stall/in_data and are taken at an edge with
// in_valid high and in_stall low. Each request is a command byte, a display
// memory write or a pixel read, and yields exactly one result on
// out_valid/out_stall/out_data carrying the pixel shade (reads only) and the
// register state after the request.
// Throughput is one request per cycle while the receiver does not stall;
// the even and odd banks deliver both bytes of a column in one read. The
// memory read is registered at the accepting edge; the result register
// loads when the read stage advances, and out_valid rises with it.
// After reset, in_stall stays high while the memory is swept to zero. When
// the receiver stalls, the result is held and one more request can wait in
// the read stage; beyond that in_stall rises.
module lcd_command_decoder_and_scanout (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdc_pkg::lcdc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcdc_pkg::lcdc_out_t out_data
);

  lcdc_pkg::lcdc_regs_t regs, regs_nxt;
  logic       accept, clr_busy;
  logic       pix_en;
  logic [5:0] page_sum;
  logic [3:0] page_sel;
  logic [3:0] page_tbl [64];
  logic [11:0] col_lin;
  logic [7:0] rd_even, rd_odd;

  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_pix_en_r;
  logic [2:0]           s1_bit_r;
  lcdc_pkg::lcdc_regs_t s1_regs_r;
  logic                 s1_adv;

  logic                 out_valid_r, out_valid_nxt;
  lcdc_pkg::lcdc_out_t  out_data_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clr_busy || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;

  lcdc_cmd_dec u_cmd_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_we    (accept && (in_data.op == lcdc_pkg::OP_CMD)),
    .cmd_byte  (in_data.byte_value),
    .regs_o    (regs),
    .regs_nxt_o(regs_nxt)
  );

  // Page wrap lookup: (row page + offset) mod page count
  for (genvar g = 0; g < 64; g++) begin : g_page_tbl
    assign page_tbl[g] = 4'(g % lcdc_pkg::NUM_PAGES);
  end

  always_comb begin
    pix_en = (in_data.op == lcdc_pkg::OP_READ) && !regs.sleep
          && (8'(in_data.pixel_x) < 8'(lcdc_pkg::WIDTH_PX))
          && (8'(in_data.pixel_y) < 8'(lcdc_pkg::HEIGHT_PX));
    page_sum = 6'(in_data.pixel_y[5:3]) + 6'(regs.offset);
    page_sel = page_tbl[page_sum];
    col_lin  = 12'(page_sel) * 12'(lcdc_pkg::COLUMNS_PER_PAGE)
             + 12'(in_data.pixel_x);
  end

  lcdc_disp_mem u_disp_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_data.op == lcdc_pkg::OP_WRITE)),
    .wr_addr (in_data.mem_address),
    .wr_data (in_data.byte_value),
    .rd_en   (accept && pix_en),
    .rd_col  (col_lin[lcdc_pkg::BANK_AW-1:0]),
    .rd_even (rd_even),
    .rd_odd  (rd_odd),
    .clr_busy(clr_busy)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept)      s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    out_valid_nxt = s1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_en_r <= pix_en;
      s1_bit_r    <= in_data.pixel_y[2:0];
      s1_regs_r   <= regs_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.palette_index  <= s1_pix_en_r ?
                                   {rd_even[s1_bit_r], rd_odd[s1_bit_r]} : 2'b00;
      out_data_r.contrast_level <= s1_regs_r.contrast;
      out_data_r.power_save     <= s1_regs_r.sleep;
      out_data_r.column_address <= s1_regs_r.column;
      out_data_r.page_address   <= s1_regs_r.page;
      out_data_r.scroll_pages   <= s1_regs_r.offset;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/lcdc_shade_checker.sv @@
// Checker for the LCD controller: mirrors the command decoder, display memory and pixel fetch,
// and compares every result taken from the block against the oldest predicted one.
// Depends on lcdc_pkg for the payload structs, opcodes and command codes.
module lcdc_shade_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lcdc_pkg::lcdc_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lcdc_pkg::lcdc_out_t out_data,
  output int                  mismatches,
  output int                  awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTES_PER_COLUMN = 2;
  localparam int MEM_BYTES        = 1 << lcdc_pkg::MEM_AW;

  lcdc_pkg::lcdc_mode_t seq_mode;
  logic [7:0]  contrast_q;
  logic        sleep_q;
  logic [6:0]  column_q;
  logic [3:0]  page_q;
  logic [4:0]  offset_q;
  logic [7:0]  frame_mem [0:MEM_BYTES-1];
  lcdc_pkg::lcdc_out_t awaited_results [$];

  function automatic logic [1:0] shade_at(logic [6:0] x, logic [5:0] y);
    int         pg;
    logic [11:0] base;
    logic [7:0] b0;
    logic [7:0] b1;
    if (sleep_q || x >= lcdc_pkg::WIDTH_PX || y >= lcdc_pkg::HEIGHT_PX) return 2'd0;
    // scanout page wraps over the page count
    pg   = ((y >> 3) + offset_q) % lcdc_pkg::NUM_PAGES;
    base = 12'((pg * lcdc_pkg::COLUMNS_PER_PAGE + x) * BYTES_PER_COLUMN);
    b0   = frame_mem[base];
    b1   = frame_mem[base + 12'd1];
    return {b0[y[2:0]], b1[y[2:0]]};
  endfunction

  function automatic void take_command(logic [7:0] b);
    case (seq_mode)
      lcdc_pkg::MODE_CONTRAST: begin
        contrast_q = b;
        seq_mode   = lcdc_pkg::MODE_WAIT;
      end
      lcdc_pkg::MODE_OFFSET: begin
        offset_q = b[7:3];
        seq_mode = lcdc_pkg::MODE_WAIT;
      end
      default: begin
        seq_mode = lcdc_pkg::MODE_WAIT;
        if (b <= lcdc_pkg::CMD_COL_LO_MAX) column_q[3:0] = b[3:0];
        else if (b <= lcdc_pkg::CMD_COL_HI_MAX) column_q[6:4] = b[2:0];
        else if (b >= lcdc_pkg::CMD_OFFSET_MIN && b <= lcdc_pkg::CMD_OFFSET_MAX)
          seq_mode = lcdc_pkg::MODE_OFFSET;
        else if (b >= lcdc_pkg::CMD_PAGE_MIN && b <= lcdc_pkg::CMD_PAGE_MAX)
          page_q = b[3:0];
        else if (b == lcdc_pkg::CMD_CONTRAST) seq_mode = lcdc_pkg::MODE_CONTRAST;
        else if (b == lcdc_pkg::CMD_SLEEP_ON) sleep_q = 1'b1;
        else if (b == lcdc_pkg::CMD_SLEEP_OFF) sleep_q = 1'b0;
      end
    endcase
  endfunction

  function automatic lcdc_pkg::lcdc_out_t apply_request(lcdc_pkg::lcdc_in_t req);
    lcdc_pkg::lcdc_out_t res;
    res.palette_index = 2'd0;
    case (req.op)
      lcdc_pkg::OP_CMD:   take_command(req.byte_value);
      lcdc_pkg::OP_WRITE: frame_mem[req.mem_address] = req.byte_value;
      lcdc_pkg::OP_READ:  res.palette_index = shade_at(req.pixel_x, req.pixel_y);
      default:  ;
    endcase
    res.contrast_level = contrast_q;
    res.power_save     = sleep_q;
    res.column_address = column_q;
    res.page_address   = page_q;
    res.scroll_pages   = offset_q;
    return res;
  endfunction

  task automatic check_field(string name, logic [7:0] expv, logic [7:0] gotv);
    if (gotv !== expv) begin
      $error("%s expected %0d got %0d", name, expv, gotv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    lcdc_pkg::lcdc_out_t want;
    if (!rst_n) begin
      seq_mode   = lcdc_pkg::MODE_WAIT;
      contrast_q = '0;
      sleep_q    = 1'b0;
      column_q   = '0;
      page_q     = '0;
      offset_q   = '0;
      for (int a = 0; a < MEM_BYTES; a++) frame_mem[a] = 8'd0;
      awaited_results.delete();
    end else begin
      // a result taken now always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("palette_index", 8'(want.palette_index),
                      8'(out_data.palette_index));
          check_field("contrast_level", want.contrast_level, out_data.contrast_level);
          check_field("power_save", 8'(want.power_save), 8'(out_data.power_save));
          check_field("column_address", 8'(want.column_address),
                      8'(out_data.column_address));
          check_field("page_address", 8'(want.page_address),
                      8'(out_data.page_address));
          check_field("scroll_pages", 8'(want.scroll_pages),
                      8'(out_data.scroll_pages));
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(apply_request(in_data));
    end
    awaited = awaited_results.size();
  end

endmodule

@@ bench/tb_lcd_command_decoder_and_scanout.sv @@
// Top of the LCD controller bench: clock, reset, request stimulus and result back-pressure.
// Instantiates lcd_command_decoder_and_scanout and lcdc_shade_checker; uses lcdc_pkg.
module tb_lcd_command_decoder_and_scanout;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [7:0] CMD_UNKNOWN = 8'h55;
  localparam logic [7:0] CMD_ALL_ONE = 8'hFF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_LIMIT   = 10000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  lcdc_pkg::lcdc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  lcdc_pkg::lcdc_out_t out_data;
  int        mismatches;
  int        awaited;
  logic      hold_request;
  int        burst_left = 0;
  int        sent = 0;

  always #10 clk = ~clk;

  lcd_command_decoder_and_scanout DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  lcdc_shade_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  function automatic lcdc_pkg::lcdc_in_t random_req(logic [1:0] op);
    lcdc_pkg::lcdc_in_t r;
    r.op          = op;
    r.byte_value  = 8'($urandom);
    r.mem_address = 12'($urandom);
    r.pixel_x     = 7'($urandom);
    r.pixel_y     = 6'($urandom);
    return r;
  endfunction

  // Offer one request in the current burst; open a new burst, often after an idle gap, when it runs out.
  task automatic drive_request(lcdc_pkg::lcdc_in_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic send_cmd(logic [7:0] b);
    lcdc_pkg::lcdc_in_t req;
    req = random_req(lcdc_pkg::OP_CMD);
    req.byte_value = b;
    drive_request(req);
  endtask

  task automatic send_write(logic [11:0] addr, logic [7:0] b);
    lcdc_pkg::lcdc_in_t req;
    req = random_req(lcdc_pkg::OP_WRITE);
    req.mem_address = addr;
    req.byte_value  = b;
    drive_request(req);
  endtask

  task automatic send_read(logic [6:0] x, logic [5:0] y);
    lcdc_pkg::lcdc_in_t req;
    req = random_req(lcdc_pkg::OP_READ);
    req.pixel_x = x;
    req.pixel_y = y;
    drive_request(req);
  endtask

  task automatic send_command_group();
    case ($urandom_range(0, 9))
      0: send_cmd(lcdc_pkg::CMD_COL_LO_MIN | 8'($urandom_range(0, 15)));
      1: send_cmd(lcdc_pkg::CMD_COL_HI_MIN | 8'($urandom_range(0, 7)));
      2: send_cmd(lcdc_pkg::CMD_PAGE_MIN | 8'($urandom_range(0, 15)));
      3: begin
        send_cmd(lcdc_pkg::CMD_CONTRAST);
        send_cmd(8'($urandom));
      end
      4: begin
        send_cmd(lcdc_pkg::CMD_OFFSET_MIN | 8'($urandom_range(0, 3)));
        send_cmd(8'($urandom));
      end
      5: send_cmd(lcdc_pkg::CMD_SLEEP_ON);
      6, 9: send_cmd(lcdc_pkg::CMD_SLEEP_OFF);
      7: send_cmd(8'($urandom));
      // lone sequence opener: whatever comes next is taken as its data byte
      default: send_cmd(($urandom_range(0, 1) == 0) ? lcdc_pkg::CMD_CONTRAST
                                                    : lcdc_pkg::CMD_OFFSET_MAX);
    endcase
  endtask

  initial begin : stimulus
    lcdc_pkg::lcdc_in_t req;
    int          len;
    logic [11:0] addr0;
    logic [6:0]  x0;
    logic [5:0]  y0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    hold_request = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // column nibbles and page range ends
    send_cmd(lcdc_pkg::CMD_COL_LO_MAX);
    send_cmd(lcdc_pkg::CMD_COL_HI_MAX);
    send_cmd(lcdc_pkg::CMD_COL_LO_MIN);
    send_cmd(lcdc_pkg::CMD_COL_HI_MIN);
    send_cmd(lcdc_pkg::CMD_PAGE_MAX);
    send_cmd(lcdc_pkg::CMD_PAGE_MIN);
    // contrast sequences, one whose data byte looks like a command
    send_cmd(lcdc_pkg::CMD_CONTRAST);
    send_cmd(CMD_ALL_ONE);
    send_cmd(lcdc_pkg::CMD_CONTRAST);
    send_cmd(lcdc_pkg::CMD_SLEEP_ON);
    // offset to the top, then back to zero through the divide by eight
    send_cmd(lcdc_pkg::CMD_OFFSET_MAX);
    send_cmd(CMD_ALL_ONE);
    send_cmd(lcdc_pkg::CMD_OFFSET_MIN);
    send_cmd(8'h07);
    send_write(12'hFFF, CMD_ALL_ONE);
    send_write(12'h000, 8'hAA);
    send_write(12'h001, 8'h55);
    send_read(7'd0, 6'd0);
    send_read(7'd95, 6'd63);
    send_read(7'd127, 6'd1);
    send_read(7'd96, 6'd0);
    // power save masks the shade
    send_cmd(lcdc_pkg::CMD_SLEEP_ON);
    send_read(7'd0, 6'd1);
    send_cmd(lcdc_pkg::CMD_SLEEP_OFF);
    send_cmd(CMD_UNKNOWN);
    send_cmd(CMD_ALL_ONE);
    req = random_req(OP_UNUSED);
    req.byte_value = CMD_ALL_ONE;
    drive_request(req);
    // page wrap: offset 15 moves row band 1 onto page 0
    send_cmd(lcdc_pkg::CMD_OFFSET_MIN);
    send_cmd(8'h78);
    send_read(7'd0, 6'd8);

    for (int base = sent; sent < base + RANDOM_ITEMS; ) begin
      if (!hold_request && sent >= base + HOLD_AT) hold_request = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: send_command_group();
        6, 7, 8, 9, 10, 11: begin
          addr0 = 12'($urandom);
          len = $urandom_range(1, 16);
          for (int i = 0; i < len; i++) send_write(addr0 + 12'(i), 8'($urandom));
        end
        19: drive_request(random_req(OP_UNUSED));
        default: begin
          // scan along a row, sometimes running off the right edge
          x0 = 7'($urandom);
          y0 = 6'($urandom);
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) send_read(x0 + 7'(i), y0);
        end
      endcase
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS lcd_command_decoder_and_scanout");
    else $display("FAIL lcd_command_decoder_and_scanout");
    $finish;
  end

  // Result side stalls on its own changing pattern, plus one long hold-off.
  initial begin : receiver
    int phase_left;
    int pattern;
    int tick;
    bit hold_done;
    out_stall  = 1'b0;
    phase_left = 0;
    pattern    = 0;
    tick       = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(32, 256);
        pattern    = $urandom_range(0, 3);
      end
      phase_left--;
      tick++;
      case (pattern)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (tick % 5 < 2);
      endcase
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("FAIL lcd_command_decoder_and_scanout");
    $finish;
  end

endmodule
